>>> hw/rtl/dqne_pkg.sv
// Shared types and constants for the DNS query name extractor.
package dqne_pkg;

  localparam int unsigned DefaultMaxPacketBytes = 65535;

  localparam logic [7:0]  ResetMatchProtocol = 8'd17;
  localparam logic [15:0] ResetMatchPort     = 16'd53;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam logic [CfgIdxW-1:0] CfgMatchProtocol = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMatchPort     = 2'd1;

  localparam int unsigned ProtocolPos    = 9;
  localparam int unsigned PortHighOffset = 2;
  localparam int unsigned PortLowOffset  = 3;
  localparam int unsigned UdpDnsHdrBytes = 20;
  localparam logic [3:0]  HdrLenMask     = 4'hF;
  localparam logic [7:0]  DotChar        = 8'h2E;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    PhBefore = 2'd0,
    PhLength = 2'd1,
    PhLabel  = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       name_last;
  } out_t;

  // Work handed from the parser to the emitter.
  typedef struct packed {
    logic       finish;
    logic       has_char;
    logic       is_dot;
    logic [7:0] char_val;
  } token_t;

endpackage

>>> hw/rtl/dqne_front.sv
// Parser: tracks packet position and headers, turns each byte into an emit token.
module dqne_front #(
  parameter int unsigned MAX_PACKET_BYTES = dqne_pkg::DefaultMaxPacketBytes
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dqne_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dqne_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  dqne_pkg::in_t                  in_data_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output dqne_pkg::token_t               q_token_o
);

  localparam int unsigned PosW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PACKET_BYTES);

  logic [7:0]      match_protocol_q;
  logic [15:0]     match_port_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [5:0]      hdr_bytes_q, hdr_bytes_d;
  logic            proto_ok_q, proto_ok_d;
  logic [7:0]      port_high_q, port_high_d;
  logic            port_ok_q, port_ok_d;
  logic [7:0]      label_rem_q, label_rem_d;
  dqne_pkg::phase_e phase_q, phase_d;

  logic            accept;
  logic [7:0]      b;
  logic [PosW-1:0] hl;
  logic            finish;
  logic            has_char;
  logic            is_dot;
  logic [7:0]      char_val;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_protocol_q <= dqne_pkg::ResetMatchProtocol;
      match_port_q     <= dqne_pkg::ResetMatchPort;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dqne_pkg::CfgMatchProtocol: match_protocol_q <= cfg_wdata_i[7:0];
        dqne_pkg::CfgMatchPort:     match_port_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr_bytes_q <= '0;
      proto_ok_q  <= 1'b0;
      port_high_q <= '0;
      port_ok_q   <= 1'b0;
      label_rem_q <= '0;
      phase_q     <= dqne_pkg::PhBefore;
    end else if (accept) begin
      pos_q       <= pos_d;
      hdr_bytes_q <= hdr_bytes_d;
      proto_ok_q  <= proto_ok_d;
      port_high_q <= port_high_d;
      port_ok_q   <= port_ok_d;
      label_rem_q <= label_rem_d;
      phase_q     <= phase_d;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    hdr_bytes_d = hdr_bytes_q;
    proto_ok_d  = proto_ok_q;
    port_high_d = port_high_q;
    port_ok_d   = port_ok_q;
    label_rem_d = label_rem_q;
    phase_d     = phase_q;
    finish      = 1'b0;
    has_char    = 1'b0;
    is_dot      = 1'b0;
    char_val    = b;
    hl          = PosW'(hdr_bytes_q);

    if (pos_q != MaxPos) begin
      if (pos_q == '0) begin
        hdr_bytes_d = {b[3:0] & dqne_pkg::HdrLenMask, 2'b00};
      end
      if (pos_q == PosW'(dqne_pkg::ProtocolPos)) begin
        proto_ok_d = (b == match_protocol_q);
      end
      hl = PosW'(hdr_bytes_d);
      if (pos_q == hl + PosW'(dqne_pkg::PortHighOffset)) begin
        port_high_d = b;
      end
      if (pos_q == hl + PosW'(dqne_pkg::PortLowOffset)) begin
        port_ok_d = ({port_high_q, b} == match_port_q);
      end
      if (phase_q == dqne_pkg::PhBefore && pos_q == hl + PosW'(dqne_pkg::UdpDnsHdrBytes)
          && proto_ok_d && port_ok_d) begin
        phase_d = dqne_pkg::PhLength;
      end

      unique case (phase_d)
        dqne_pkg::PhLength: begin
          if (b == 8'd0) begin
            phase_d = dqne_pkg::PhDone;
            finish  = 1'b1;
          end else begin
            label_rem_d = b;
            phase_d     = dqne_pkg::PhLabel;
            // dot only between labels; the emitter drops it before the first
            has_char    = 1'b1;
            is_dot      = 1'b1;
            char_val    = dqne_pkg::DotChar;
          end
        end
        dqne_pkg::PhLabel: begin
          has_char    = 1'b1;
          label_rem_d = label_rem_q - 8'd1;
          if (label_rem_d == 8'd0) begin
            phase_d = dqne_pkg::PhLength;
          end
        end
        default: ;
      endcase
      pos_d = pos_q + PosW'(1);
    end else if (phase_q == dqne_pkg::PhLength || phase_q == dqne_pkg::PhLabel) begin
      phase_d = dqne_pkg::PhDone;
      finish  = 1'b1;
    end

    if (in_data_i.packet_end) begin
      finish      = 1'b1;
      pos_d       = '0;
      hdr_bytes_d = '0;
      proto_ok_d  = 1'b0;
      port_high_d = '0;
      port_ok_d   = 1'b0;
      label_rem_d = '0;
      phase_d     = dqne_pkg::PhBefore;
    end
  end

  assign q_push_o           = accept && (finish || has_char);
  assign q_token_o.finish   = finish;
  assign q_token_o.has_char = has_char;
  // the emitter skips a dot when nothing is held
  assign q_token_o.is_dot   = is_dot;
  assign q_token_o.char_val = char_val;

endmodule

>>> hw/rtl/dqne_queue.sv
// Two-word queue between the parser and the emitter.
module dqne_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dqne_pkg::token_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output dqne_pkg::token_t data_o
);

  localparam int unsigned PtrW = $clog2(dqne_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(dqne_pkg::QueueDepth + 1);

  dqne_pkg::token_t     mem_q [dqne_pkg::QueueDepth];
  logic [PtrW-1:0]      wptr_q, rptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(dqne_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(dqne_pkg::QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(dqne_pkg::QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/dqne_back.sv
// Emitter: holds one character back so the final one can carry the last mark.
module dqne_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  dqne_pkg::token_t q_token_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dqne_pkg::out_t   out_data_o
);

  logic           held_valid_q, held_valid_d;
  logic [7:0]     held_char_q, held_char_d;
  logic           out_valid_q;
  dqne_pkg::out_t out_q;
  logic           has_new;
  logic           emit;
  dqne_pkg::out_t emit_word;
  logic           pop;

  // drop a dot that would open the name
  assign has_new = q_token_i.has_char && (!q_token_i.is_dot || held_valid_q);

  always_comb begin
    held_valid_d        = held_valid_q;
    held_char_d         = held_char_q;
    emit                = 1'b0;
    emit_word.name_char = held_char_q;
    emit_word.name_last = 1'b0;
    if (q_token_i.finish) begin
      // a final character from the last byte is dropped if one is already held
      emit                = held_valid_q || has_new;
      emit_word.name_char = held_valid_q ? held_char_q : q_token_i.char_val;
      emit_word.name_last = 1'b1;
      held_valid_d        = 1'b0;
      held_char_d         = '0;
    end else if (has_new) begin
      emit         = held_valid_q;
      held_char_d  = q_token_i.char_val;
      held_valid_d = 1'b1;
    end
  end

  assign pop     = q_valid_i && (!emit || !out_valid_q || out_ready_i);
  assign q_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_char_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop) begin
        held_valid_q <= held_valid_d;
        held_char_q  <= held_char_d;
      end
      if (pop && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      out_q <= emit_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/dns_query_name_extractor.sv
// DNS query name extractor top level: parser, token queue and emitter.
//
// Raw IPv4 packet bytes enter on the in channel (valid/ready), one word per
// byte with packet_end set on the final byte. Packets whose protocol byte and
// UDP destination port match the two configuration registers have their DNS
// question name sent out on the out channel, one character per word, with a
// dot between labels and name_last on the final character.
// Throughput: one byte per cycle while the queue is not full, set by the
// parser's position and label counters. The parser turns each byte into a
// token that waits in a two-word queue; the emitter drains one token a
// cycle into the output register unless that register is stalled. A
// character leaves once the next character or the name end has arrived.
// When the receiver stalls, the output register holds its word, the queue
// fills and in_ready_o drops after two more producing bytes.
// Reset restores the default match values (protocol 17, port 53) and clears
// all per-packet state; configuration writes take effect at once and must be
// made while the block is idle.
module dns_query_name_extractor #(
  parameter int unsigned MAX_PACKET_BYTES = dqne_pkg::DefaultMaxPacketBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dqne_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dqne_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dqne_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dqne_pkg::out_t                out_data_o
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  dqne_pkg::token_t push_token;
  dqne_pkg::token_t head_token;

  dqne_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_token_o   (push_token)
  );

  dqne_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_token),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head_token)
  );

  dqne_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_token_i   (head_token),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> bench/testbench.sv
// Testbench for the DNS query name extractor: random IPv4/UDP frames, scoreboard check.
module testbench;

  localparam int unsigned MaxBytes    = 128;
  localparam int unsigned PhaseBytes  = 255;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned StallLimit  = 2000;

  // Predicts the name characters of each packet and holds them until they leave.
  class qname_scoreboard;
    int unsigned byte_cap;
    logic [7:0]  match_proto;
    logic [15:0] match_port;
    logic [15:0] byte_pos;
    logic [5:0]  hdr_bytes;
    logic        proto_ok;
    logic        port_ok;
    logic [7:0]  port_hi;
    logic [7:0]  label_left;
    dqne_pkg::phase_e phase;
    logic [7:0]  held_char;
    logic        held_valid;
    dqne_pkg::out_t expected_q[$];
    int          errors;

    function new(int unsigned max_bytes);
      byte_cap    = max_bytes;
      errors      = 0;
      match_proto = dqne_pkg::ResetMatchProtocol;
      match_port  = dqne_pkg::ResetMatchPort;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_pos   = '0;
      hdr_bytes  = '0;
      proto_ok   = 1'b0;
      port_ok    = 1'b0;
      port_hi    = '0;
      label_left = '0;
      phase      = dqne_pkg::PhBefore;
      held_char  = '0;
      held_valid = 1'b0;
    endfunction

    function void set_match(logic [7:0] proto, logic [15:0] port);
      match_proto = proto;
      match_port  = port;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_char(logic [7:0] c, logic last);
      dqne_pkg::out_t r;
      r.name_char = c;
      r.name_last = last;
      expected_q.push_back(r);
    endfunction

    function void note_byte(dqne_pkg::in_t w);
      logic        finish;
      logic        have_new;
      logic [7:0]  new_char;
      int unsigned p;
      int unsigned hl;
      finish   = 1'b0;
      have_new = 1'b0;
      new_char = '0;
      if (byte_pos < byte_cap) begin
        p = byte_pos;
        if (p == 0) hdr_bytes = {w.data_byte[3:0] & dqne_pkg::HdrLenMask, 2'b00};
        if (p == dqne_pkg::ProtocolPos) proto_ok = (w.data_byte == match_proto);
        hl = hdr_bytes;
        if (p == hl + dqne_pkg::PortHighOffset) port_hi = w.data_byte;
        if (p == hl + dqne_pkg::PortLowOffset)
          port_ok = ({port_hi, w.data_byte} == match_port);
        if (phase == dqne_pkg::PhBefore && p == hl + dqne_pkg::UdpDnsHdrBytes &&
            proto_ok && port_ok)
          phase = dqne_pkg::PhLength;
        case (phase)
          dqne_pkg::PhLength: begin
            if (w.data_byte == 8'd0) begin
              phase  = dqne_pkg::PhDone;
              finish = 1'b1;
            end else begin
              label_left = w.data_byte;
              phase      = dqne_pkg::PhLabel;
              // dot only between labels
              if (held_valid) begin
                new_char = dqne_pkg::DotChar;
                have_new = 1'b1;
              end
            end
          end
          dqne_pkg::PhLabel: begin
            new_char   = w.data_byte;
            have_new   = 1'b1;
            label_left = label_left - 8'd1;
            if (label_left == 8'd0) phase = dqne_pkg::PhLength;
          end
          default: ;
        endcase
        byte_pos = 16'(p + 1);
      end else if (phase == dqne_pkg::PhLength || phase == dqne_pkg::PhLabel) begin
        phase  = dqne_pkg::PhDone;
        finish = 1'b1;
      end

      if (w.packet_end) finish = 1'b1;

      // hold one character back so the final one can carry the last flag
      if (finish) begin
        if (held_valid) push_char(held_char, 1'b1);
        else if (have_new) push_char(new_char, 1'b1);
        held_valid = 1'b0;
        held_char  = '0;
      end else if (have_new) begin
        if (held_valid) push_char(held_char, 1'b0);
        held_char  = new_char;
        held_valid = 1'b1;
      end

      if (w.packet_end) clear_packet();
    endfunction

    function void check_char(dqne_pkg::out_t got);
      dqne_pkg::out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected word: name_char 0x%02h name_last %0b", got.name_char,
               got.name_last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.name_char !== want.name_char) begin
        $error("name_char: expected 0x%02h, got 0x%02h", want.name_char, got.name_char);
        errors++;
      end
      if (got.name_last !== want.name_last) begin
        $error("name_last: expected %0b, got %0b", want.name_last, got.name_last);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i     = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [dqne_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [dqne_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  dqne_pkg::in_t                 in_data   = '0;
  logic                          in_ready_o;
  logic                          out_valid_o;
  logic                          out_ready = 1'b0;
  dqne_pkg::out_t                out_data_o;

  qname_scoreboard sb;
  logic [7:0]      frame_q[$];
  int unsigned     bytes_sent  = 0;
  int              tx_mode     = 0;
  int              rx_mode     = 0;
  int              rx_wait     = 0;
  int unsigned     idle_cycles = 0;

  dns_query_name_extractor #(.MAX_PACKET_BYTES(MaxBytes)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // Note accepted bytes before checking results so same-edge order never matters.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) sb.note_byte(in_data);
      if (out_valid_o && out_ready) sb.check_char(out_data_o);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: after each word, stall a random number of cycles drawn by the receive mode (none in mode 0).
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) rx_wait = draw_gap(rx_mode);
      else if (rx_wait > 0) rx_wait--;
      out_ready <= (rx_wait == 0);
    end
  end

  function automatic void trim_frame(int unsigned keep);
    while (frame_q.size() > keep) void'(frame_q.pop_back());
  endfunction

  function automatic void add_label(int unsigned len, int unsigned nchars);
    frame_q.push_back(8'(len));
    repeat (nchars) frame_q.push_back(8'($urandom));
  endfunction

  // IP header of ihl words, UDP and DNS headers; protocol and port from the registers.
  function automatic void start_frame(int unsigned ihl);
    int unsigned hl;
    hl = ihl * 4;
    frame_q.delete();
    repeat (hl + dqne_pkg::UdpDnsHdrBytes) frame_q.push_back(8'($urandom));
    frame_q[0]                               = {4'($urandom), 4'(ihl)};
    frame_q[dqne_pkg::ProtocolPos]           = sb.match_proto;
    frame_q[hl + dqne_pkg::PortHighOffset]   = sb.match_port[15:8];
    frame_q[hl + dqne_pkg::PortLowOffset]    = sb.match_port[7:0];
  endfunction

  function automatic void build_random_frame();
    int unsigned kind;
    int unsigned ihl;
    int unsigned hl;
    int unsigned len;
    int unsigned sel;
    int unsigned pos;
    kind = $urandom_range(0, 99);
    ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
    hl   = ihl * 4;
    if (kind < 8) begin
      // noise
      frame_q.delete();
      repeat ($urandom_range(1, 60)) frame_q.push_back(8'($urandom));
      return;
    end
    start_frame(ihl);
    if ($urandom_range(0, 9) == 0) begin
      // break the protocol or port match by one bit
      sel = $urandom_range(0, 2);
      pos = (sel == 0) ? dqne_pkg::ProtocolPos :
            (sel == 1) ? hl + dqne_pkg::PortHighOffset : hl + dqne_pkg::PortLowOffset;
      frame_q[pos] = frame_q[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    if (kind < 16) begin
      trim_frame($urandom_range(1, hl + dqne_pkg::UdpDnsHdrBytes));
      return;
    end
    if (kind < 22) begin
      // name still running around the byte cap, cut just before or past it
      while (frame_q.size() < MaxBytes + 8) add_label(63, 63);
      trim_frame(MaxBytes - 2 + $urandom_range(0, 8));
      return;
    end
    if (kind < 30) begin
      if ($urandom_range(0, 1) == 1) frame_q.push_back(8'd0);
      else add_label(8'hC0 | $urandom_range(0, 63), $urandom_range(0, 20));
      repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 4)) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 63) : $urandom_range(1, 12);
      add_label(len, len);
    end
    frame_q.push_back(8'd0);
    repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom));
    if (kind < 45) begin
      trim_frame($urandom_range(hl + dqne_pkg::UdpDnsHdrBytes + 1, frame_q.size()));
    end
  endfunction

  task automatic send_word(dqne_pkg::in_t w);
    int gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_frame();
    dqne_pkg::in_t w;
    tx_mode = $urandom_range(0, 2);
    rx_mode = $urandom_range(0, 2);
    for (int i = 0; i < frame_q.size(); i++) begin
      w.data_byte  = frame_q[i];
      w.packet_end = (i == frame_q.size() - 1);
      send_word(w);
    end
  endtask

  // Hold the sender until every expected character has left and the pipe is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_match(logic [7:0] proto, logic [15:0] port);
    cfg_we    <= 1'b1;
    cfg_idx   <= dqne_pkg::CfgMatchProtocol;
    cfg_wdata <= {8'($urandom), proto};
    @(posedge clk_i);
    cfg_idx   <= dqne_pkg::CfgMatchPort;
    cfg_wdata <= port;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_match(proto, port);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      build_random_frame();
      send_frame();
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
  endtask

  initial begin
    sb = new(MaxBytes);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one-byte packet, then a minimal header with a two-label name of extreme bytes
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame();
    start_frame(0);
    frame_q.push_back(8'd1);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'd1);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'd0);
    send_frame();
    run_random(PhaseBytes);
    wait_idle();

    set_match(8'h00, 16'h0000);
    run_random(PhaseBytes);
    wait_idle();

    set_match(8'hFF, 16'hFFFF);
    run_random(PhaseBytes);
    wait_idle();

    set_match(8'($urandom), 16'($urandom));
    run_random(PhaseBytes);
    wait_idle();

    set_match(dqne_pkg::ResetMatchProtocol, dqne_pkg::ResetMatchPort);
    run_random(PhaseBytes);
    wait_idle();

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
